@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on the rising clock, off while reset is low
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent assertion sampled on the rising clock, checked in reset too
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/core/shrb_pkg.sv @@
// types, codes and sizes shared by the source hit-rate blocker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shrb_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int THR_W   = 14;
    localparam int WIN_W   = 24;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW   = 2'd1;

    // input function codes
    localparam logic [1:0] FUNC_HIT   = 2'd0;
    localparam logic [1:0] FUNC_BLOCK = 2'd1;

    // verdict codes
    localparam logic [2:0] VERDICT_INSTANT   = 3'd0;
    localparam logic [2:0] VERDICT_DOUBLE    = 3'd1;
    localparam logic [2:0] VERDICT_STALE     = 3'd2;
    localparam logic [2:0] VERDICT_WINDOW    = 3'd3;
    localparam logic [2:0] VERDICT_FULL_DROP = 3'd4;

    // one table entry
    typedef struct packed {
        logic [31:0]        address;
        logic [31:0]        first_seen;
        logic [COUNT_W-1:0] hit_count;
    } entry_t;

    // table write and valid-bit control
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             set_en;
        logic             clr_en;
        logic [IDX_W-1:0] vld_idx;
    } tbl_ctl_t;

    // thresholds and windows with their multiples
    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [THR_W:0]   thr2;
        logic [THR_W+1:0] thr3;
        logic [WIN_W-1:0] win;
        logic [WIN_W+1:0] win3;
    } limits_t;

    // outcome of evaluating one entry
    typedef struct packed {
        logic       match;
        logic       is_free;
        logic       emit;
        logic       remove;
        logic [2:0] verdict;
    } eval_t;

    // result request from the sequencer to the output stage
    typedef struct packed {
        logic        push;
        logic        flush;
        logic [31:0] ip;
        logic [2:0]  verdict;
    } res_req_t;

    // output stage status
    typedef struct packed {
        logic can_push;
        logic flush_ok;
    } res_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/shrb_table.sv @@
// source table: entry memory with registered read and per-entry valid bits
// depends on shrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module shrb_table
    import shrb_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [IDX_W-1:0]         rd_addr,
    output entry_t                        rd_data,
    input  wire tbl_ctl_t                 ctl,
    output logic [TABLE_ENTRIES-1:0]      valid
);

    entry_t                   mem [TABLE_ENTRIES];
    entry_t                   rd_data_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // entry memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.set_en)
        begin
            valid_reg[ctl.vld_idx] <= 1'b1;
        end
        else if (ctl.clr_en)
        begin
            valid_reg[ctl.vld_idx] <= 1'b0;
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/shrb_eval.sv @@
// shared compare unit: address match during lookup, age and hit rules during sweep
// depends on shrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module shrb_eval
    import shrb_pkg::*;
(
    input  wire logic        entry_valid,
    input  wire entry_t      entry,
    input  wire logic [31:0] ip,
    input  wire logic [31:0] now,
    input  wire limits_t     lim,
    output eval_t            res
);

    logic [31:0] age;
    logic        over_double;
    logic        over_triple;
    logic        over_single;
    logic        stale;
    logic        in_window;

    // age wraps modulo 2^32
    assign age         = now - entry.first_seen;
    assign over_double = entry.hit_count >= COUNT_W'(lim.thr2);
    assign over_triple = entry.hit_count >= COUNT_W'(lim.thr3);
    assign over_single = entry.hit_count >= COUNT_W'(lim.thr);
    assign stale       = age > 32'(lim.win3);
    assign in_window   = age <= 32'(lim.win);

    // rule selection
    always_comb
    begin
        res         = '0;
        res.match   = entry_valid && (entry.address == ip);
        res.is_free = !entry_valid;
        if (entry_valid)
        begin
            if (over_double)
            begin
                res.emit    = 1'b1;
                res.remove  = 1'b1;
                res.verdict = VERDICT_DOUBLE;
            end
            else if (stale)
            begin
                res.emit    = over_triple;
                res.remove  = 1'b1;
                res.verdict = VERDICT_STALE;
            end
            else if (in_window && over_single)
            begin
                res.emit    = 1'b1;
                res.remove  = 1'b1;
                res.verdict = VERDICT_WINDOW;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/shrb_out.sv @@
// result stage: one held result plus the output register, marks the final one
// depends on shrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module shrb_out
    import shrb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire res_req_t    req,
    output res_stat_t        stat,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      blocked_ip,
    output logic [2:0]       verdict,
    output logic             last
);

    logic        pend_valid_reg;
    logic [31:0] pend_ip_reg;
    logic [2:0]  pend_verdict_reg;
    logic        out_valid_reg;
    logic [31:0] out_ip_reg;
    logic [2:0]  out_verdict_reg;
    logic        out_last_reg;
    logic        out_free;

    assign out_free      = !out_valid_reg || !out_stall;
    assign stat.can_push = !pend_valid_reg || out_free;
    assign stat.flush_ok = !pend_valid_reg || out_free;

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (req.flush && out_free)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_valid_reg && out_free && (req.push || req.flush))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: a held result moves out when a newer one arrives or at the end
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            pend_ip_reg      <= req.ip;
            pend_verdict_reg <= req.verdict;
        end
        if (pend_valid_reg && out_free && (req.push || req.flush))
        begin
            out_ip_reg      <= pend_ip_reg;
            out_verdict_reg <= pend_verdict_reg;
            out_last_reg    <= !req.push;
        end
    end

    assign out_valid  = out_valid_reg;
    assign blocked_ip = out_ip_reg;
    assign verdict    = out_verdict_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/source_hit_rate_blocker.sv @@
// top level of the source hit-rate blocker: sequencer and configuration
// depends on shrb_pkg, shrb_table, shrb_eval, shrb_out
`timescale 1ns / 1ps
`default_nettype none

// Keeps a table of TABLE_ENTRIES sources with first-seen time and hit count.
// One transaction is taken at a time; in_stall stays high until all its
// results are handed to the output register. A hit walks the table once to
// find the address or the lowest free entry, then passes through the table
// update state and a state that restarts the read; then every item sweeps
// all TABLE_ENTRIES entries one per cycle, unless a result that cannot be
// pushed holds the sweep, through the single compare unit and a registered
// memory read. Configuration is to be written only while idle, by the user;
// the block does not enforce it. No clearing pass is needed after reset.
module source_hit_rate_blocker
    import shrb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           func,
    input  wire logic [31:0]          src_ip,
    input  wire logic [31:0]          now_seconds,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [31:0]               blocked_ip,
    output logic [2:0]                verdict,
    output logic                      last
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_PRIME  = 6'b001000,
        ST_SWEEP  = 6'b010000,
        ST_FLUSH  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      ip_reg;
    logic [31:0]      now_reg;
    logic             found_reg, found_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    entry_t           match_reg, match_next;
    limits_t          lim_reg;

    entry_t                   rd_data;
    logic [TABLE_ENTRIES-1:0] valid;
    tbl_ctl_t                 tbl_ctl;
    eval_t                    ev;
    res_req_t                 req;
    res_stat_t                stat;
    logic                     accept;
    logic                     cur_valid;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cur_valid = valid[idx_reg];

    // configuration registers with precomputed multiples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.thr  <= THR_W'(6);
            lim_reg.thr2 <= (THR_W+1)'(12);
            lim_reg.thr3 <= (THR_W+2)'(18);
            lim_reg.win  <= WIN_W'(120);
            lim_reg.win3 <= (WIN_W+2)'(360);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HIT_THRESHOLD:
                begin
                    lim_reg.thr  <= cfg_data[THR_W-1:0];
                    lim_reg.thr2 <= {cfg_data[THR_W-1:0], 1'b0};
                    lim_reg.thr3 <= {2'b00, cfg_data[THR_W-1:0]}
                                  + {1'b0, cfg_data[THR_W-1:0], 1'b0};
                end
                CFG_TIME_WINDOW:
                begin
                    lim_reg.win  <= cfg_data[WIN_W-1:0];
                    lim_reg.win3 <= {2'b00, cfg_data[WIN_W-1:0]}
                                  + {1'b0, cfg_data[WIN_W-1:0], 1'b0};
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
        end
    end

    // transaction payload and lookup results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ip_reg  <= src_ip;
            now_reg <= now_seconds;
        end
        slot_reg  <= slot_next;
        match_reg <= match_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        match_next      = match_reg;
        tbl_ctl         = '0;
        req             = '0;
        req.ip          = ip_reg;
        req.verdict     = VERDICT_INSTANT;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    if (func == FUNC_HIT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_SWEEP;
                        if (func == FUNC_BLOCK)
                        begin
                            req.push    = 1'b1;
                            req.ip      = src_ip;
                            req.verdict = VERDICT_INSTANT;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (ev.match)
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                    match_next = rd_data;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    if (ev.is_free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        slot_next       = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_UPDATE:
            begin
                idx_next = '0;
                if (found_reg)
                begin
                    tbl_ctl.wr_en   = 1'b1;
                    tbl_ctl.wr_addr = slot_reg;
                    tbl_ctl.wr_data = match_reg;
                    if (match_reg.hit_count != COUNT_MAX)
                    begin
                        tbl_ctl.wr_data.hit_count = match_reg.hit_count + 1'b1;
                    end
                    state_next = ST_PRIME;
                end
                else if (free_found_reg)
                begin
                    tbl_ctl.wr_en              = 1'b1;
                    tbl_ctl.wr_addr            = slot_reg;
                    tbl_ctl.wr_data.address    = ip_reg;
                    tbl_ctl.wr_data.first_seen = now_reg;
                    tbl_ctl.wr_data.hit_count  = COUNT_W'(1);
                    tbl_ctl.set_en             = 1'b1;
                    tbl_ctl.vld_idx            = slot_reg;
                    state_next                 = ST_PRIME;
                end
                else if (stat.can_push)
                begin
                    // table full, report the dropped hit
                    req.push    = 1'b1;
                    req.verdict = VERDICT_FULL_DROP;
                    state_next  = ST_PRIME;
                end
            end

            ST_PRIME:
            begin
                // read of entry zero starts after the update has landed
                idx_next   = '0;
                state_next = ST_SWEEP;
            end

            ST_SWEEP:
            begin
                if (!(ev.emit && !stat.can_push))
                begin
                    tbl_ctl.clr_en = ev.remove;
                    tbl_ctl.vld_idx = idx_reg;
                    req.push       = ev.emit;
                    req.ip         = rd_data.address;
                    req.verdict    = ev.verdict;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                req.flush = 1'b1;
                if (stat.flush_ok)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    shrb_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_next),
        .rd_data (rd_data),
        .ctl     (tbl_ctl),
        .valid   (valid)
    );

    shrb_eval u_eval (
        .entry_valid (cur_valid),
        .entry       (rd_data),
        .ip          (ip_reg),
        .now         (now_reg),
        .lim         (lim_reg),
        .res         (ev)
    );

    shrb_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .blocked_ip (blocked_ip),
        .verdict    (verdict),
        .last       (last)
    );

endmodule

`default_nettype wire

@@ rtl/core/shrb_checker.sv @@
// port-level checks for the source hit-rate blocker, bound to the top level
// depends on shrb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module shrb_checker
    import shrb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] blocked_ip,
    input  wire logic [2:0]  verdict,
    input  wire logic        last
);

    // an accepted transaction keeps the block busy in the next cycle
    `ASSERT_RST(a_busy_after_accept, clk, rst_n,
        (in_valid && !in_stall) |=> in_stall,
        "block took a second transaction right after the first")

    // a stalled result holds its value
    `ASSERT_RST(a_out_hold, clk, rst_n,
        (out_valid && out_stall) |=>
            (out_valid && $stable(blocked_ip) && $stable(verdict) && $stable(last)),
        "stalled result changed")

    // only defined verdict codes leave the block
    `ASSERT_RST(a_verdict_code, clk, rst_n,
        out_valid |-> (verdict <= VERDICT_FULL_DROP),
        "undefined verdict code")

    // block comes out of reset ready and with no result
    `ASSERT_ALWAYS(a_reset_idle, clk,
        !rst_n |=> (!in_stall && !out_valid) || rst_n,
        "block not idle after reset")

endmodule

bind source_hit_rate_blocker shrb_checker u_shrb_checker (.*);

`default_nettype wire

@@ tb/tb_source_hit_rate_blocker.sv @@
// testbench for the source hit-rate blocker: directed and random transactions
// checked against an internal table predictor; depends on shrb_pkg and the rtl
`timescale 1ns / 1ps

module tb_source_hit_rate_blocker;
    import shrb_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] FUNC_SWEEP = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int DRAIN_CYCLES = 80;
    localparam int TOTAL_ITEMS  = 130;

    typedef enum int {MODE_REPEAT, MODE_FLOOD, MODE_NOISE} phase_mode_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [2:0]  verdict;
        logic        last;
    } block_report_t;

    // table predictor and queue of block reports still owed by the dut
    class blocker_scoreboard;
        bit [THR_W-1:0]   limit_hits;
        bit [WIN_W-1:0]   window_len;
        bit               slot_used [TABLE_ENTRIES];
        bit [31:0]        slot_ip [TABLE_ENTRIES];
        bit [31:0]        slot_since [TABLE_ENTRIES];
        bit [COUNT_W-1:0] slot_count [TABLE_ENTRIES];
        block_report_t    item_reports [$];
        block_report_t    due_reports [$];
        int               errors;

        function new();
            limit_hits = 6;
            window_len = 120;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_HIT_THRESHOLD)
                limit_hits = data[THR_W-1:0];
            else if (idx == CFG_TIME_WINDOW)
                window_len = data[WIN_W-1:0];
        endfunction

        function void add_report(logic [31:0] ip, logic [2:0] code);
            block_report_t rep;
            rep.ip = ip;
            rep.verdict = code;
            rep.last = 1'b0;
            item_reports = {item_reports, rep};
        endfunction

        // predict the reports of one accepted transaction
        function void take_item(logic [1:0] f, logic [31:0] ip, logic [31:0] now);
            int free_idx;
            bit found;
            bit [31:0] age;
            longint unsigned cnt, thr1, thr2, thr3, win1, win3;
            item_reports.delete();
            free_idx = -1;
            found = 1'b0;
            thr1 = limit_hits;
            thr2 = thr1 * 2;
            thr3 = thr1 * 3;
            win1 = window_len;
            win3 = win1 * 3;

            // hit lookup or allocation of the lowest free slot
            if (f == FUNC_HIT)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (slot_used[i] && slot_ip[i] == ip)
                    begin
                        if (slot_count[i] != COUNT_MAX)
                            slot_count[i]++;
                        found = 1'b1;
                        break;
                    end
                    if (!slot_used[i] && free_idx < 0)
                        free_idx = i;
                end
                if (!found)
                begin
                    if (free_idx < 0)
                    begin
                        add_report(ip, VERDICT_FULL_DROP);
                    end
                    else
                    begin
                        slot_used[free_idx] = 1'b1;
                        slot_ip[free_idx] = ip;
                        slot_since[free_idx] = now;
                        slot_count[free_idx] = COUNT_W'(1);
                    end
                end
            end
            else if (f == FUNC_BLOCK)
            begin
                add_report(ip, VERDICT_INSTANT);
            end

            // sweep every used slot in ascending order
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (slot_used[i])
                begin
                    cnt = slot_count[i];
                    age = now - slot_since[i];
                    if (cnt >= thr2)
                    begin
                        add_report(slot_ip[i], VERDICT_DOUBLE);
                        slot_used[i] = 1'b0;
                    end
                    else if (age > win3)
                    begin
                        if (cnt >= thr3)
                            add_report(slot_ip[i], VERDICT_STALE);
                        slot_used[i] = 1'b0;
                    end
                    else if (age <= win1 && cnt >= thr1)
                    begin
                        add_report(slot_ip[i], VERDICT_WINDOW);
                        slot_used[i] = 1'b0;
                    end
                end
            end

            if (item_reports.size() > 0)
                item_reports[item_reports.size() - 1].last = 1'b1;
            due_reports = {due_reports, item_reports};
        endfunction

        // compare one accepted result with the oldest owed report
        function void check_report(logic [31:0] ip, logic [2:0] code, logic fin);
            block_report_t want;
            if (due_reports.size() == 0)
            begin
                $error("unexpected result: blocked_ip %h verdict %0d last %0b",
                       ip, code, fin);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            if (want.ip !== ip)
            begin
                $error("blocked_ip: expected %h, got %h", want.ip, ip);
                errors++;
            end
            if (want.verdict !== code)
            begin
                $error("verdict: expected %0d, got %0d", want.verdict, code);
                errors++;
            end
            if (want.last !== fin)
            begin
                $error("last: expected %0b, got %0b", want.last, fin);
                errors++;
            end
        endfunction

        function int owed();
            return due_reports.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           func;
    logic [31:0]          src_ip;
    logic [31:0]          now_seconds;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [31:0]          blocked_ip;
    logic [2:0]           verdict;
    logic                 last;

    blocker_scoreboard sb = new();

    bit          tx_idle_on = 1'b1;
    int          stall_odds = 4;
    int          stall_left = 0;
    int          items_sent = 0;
    logic [31:0] clock_now = 32'd0;

    source_hit_rate_blocker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .src_ip      (src_ip),
        .now_seconds (now_seconds),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .blocked_ip  (blocked_ip),
        .verdict     (verdict),
        .last        (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side stalls in bursts of random length
    always @(negedge clk)
    begin
        if (stall_odds == 0)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(stall_odds, 0) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(17, 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_report(blocked_ip, verdict, last);
    end

    function automatic int pick_gap();
        if (tx_idle_on && $urandom_range(2, 0) == 0)
            return $urandom_range(18, 1);
        return 0;
    endfunction

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_item(input logic [1:0] f, input logic [31:0] ip,
                             input logic [31:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        func = f;
        src_ip = ip;
        now_seconds = now;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.take_item(f, ip, now);
        items_sent++;
    endtask

    // hold off input until every owed report has come and the sweep is done
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.owed() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // threshold goes with random upper bits that the block must ignore
    task automatic set_limits(input int unsigned thr, input int unsigned win);
        write_reg(CFG_HIT_THRESHOLD, {10'($urandom), THR_W'(thr)});
        write_reg(CFG_TIME_WINDOW, WIN_W'(win));
    endtask

    task automatic run_phase(input phase_mode_t mode, input int count);
        logic [31:0] pool [8];
        int pool_size;
        int pick;
        longint unsigned win;
        logic [1:0] f;
        logic [31:0] ip;
        pool_size = $urandom_range(6, 1);
        foreach (pool[k]) pool[k] = $urandom;
        win = sb.window_len;
        clock_now = $urandom;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(19, 0);
            case (mode)
                MODE_FLOOD:
                begin
                    f = FUNC_HIT;
                    ip = $urandom;
                    clock_now = clock_now + $urandom_range(2, 0);
                end
                MODE_NOISE:
                begin
                    f = 2'($urandom);
                    ip = $urandom;
                    clock_now = $urandom;
                end
                default:
                begin
                    // mostly repeated hits from a few sources
                    if (pick < 15)
                        f = FUNC_HIT;
                    else if (pick < 17)
                        f = FUNC_BLOCK;
                    else if (pick < 19)
                        f = FUNC_SWEEP;
                    else
                        f = FUNC_SPARE;
                    if (f == FUNC_HIT || pick == 15)
                        ip = pool[$urandom_range(pool_size - 1, 0)];
                    else
                        ip = $urandom;
                    if ($urandom_range(11, 0) == 0)
                        clock_now = clock_now + $urandom_range(32'(4 * win + 4), 0);
                    else
                        clock_now = clock_now + $urandom_range(32'(win / 2 + 1), 0);
                end
            endcase
            send_item(f, ip, clock_now);
        end
    endtask

    // stimulus
    initial
    begin
        logic [31:0] src_a, src_b, src_c, src_e, src_f;
        int sel;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = '0;
        src_ip = '0;
        now_seconds = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset limits: instant blocks, spare code, sweeps around time wrap
        send_item(FUNC_BLOCK, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_BLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_SPARE, $urandom, $urandom);
        send_item(FUNC_SWEEP, $urandom, $urandom);
        send_item(FUNC_HIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_HIT, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_SWEEP, 32'h0000_0000, 32'd5);
        wait_idle();

        // small limits: window block, double threshold, stale and edges
        set_limits(2, 10);
        src_a = $urandom;
        src_b = $urandom;
        src_c = $urandom;
        src_e = $urandom;
        src_f = $urandom;
        send_item(FUNC_HIT, src_a, 32'd1000);
        send_item(FUNC_HIT, src_a, 32'd1005);
        send_item(FUNC_HIT, src_b, 32'd1000);
        send_item(FUNC_SWEEP, src_b, 32'd1020);
        send_item(FUNC_HIT, src_b, 32'd1021);
        send_item(FUNC_HIT, src_b, 32'd1022);
        send_item(FUNC_HIT, src_b, 32'd1023);
        send_item(FUNC_HIT, src_c, 32'hFFFF_FFF0);
        send_item(FUNC_SWEEP, src_c, 32'h0000_0010);
        send_item(FUNC_HIT, src_e, 32'd2000);
        send_item(FUNC_BLOCK, src_e, 32'd2003);
        send_item(FUNC_HIT, src_e, 32'd2010);
        send_item(FUNC_HIT, src_f, 32'd3000);
        send_item(FUNC_SWEEP, src_f, 32'd3030);
        send_item(FUNC_SWEEP, src_f, 32'd3031);
        wait_idle();

        // random phases over a range of limits, extremes first
        set_limits(6, 120);
        run_phase(MODE_REPEAT, 16);
        wait_idle();
        set_limits(16383, 24'hFF_FFFF);
        run_phase(MODE_FLOOD, 20);
        wait_idle();
        set_limits(1, 1);
        run_phase(MODE_REPEAT, 16);
        wait_idle();
        // zero threshold blocks every entry on the next sweep
        set_limits(0, $urandom_range(200, 1));
        run_phase(MODE_REPEAT, 12);
        wait_idle();
        // zero window makes any nonzero age stale
        set_limits($urandom_range(6, 1), 0);
        run_phase(MODE_REPEAT, 12);
        wait_idle();
        // writes to unused register indexes change nothing
        write_reg(CFG_SPARE_A, CFG_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_W'($urandom));
        set_limits($urandom_range(10, 1), $urandom_range(300, 1));
        run_phase(MODE_NOISE, 10);
        wait_idle();

        while (items_sent < TOTAL_ITEMS - 20)
        begin
            tx_idle_on = ($urandom_range(3, 0) != 0);
            sel = $urandom_range(2, 0);
            stall_odds = (sel == 0) ? 0 : ((sel == 1) ? 2 : 6);
            set_limits($urandom_range(12, 1), $urandom_range(1000, 1));
            sel = $urandom_range(9, 0);
            if (sel < 6)
                run_phase(MODE_REPEAT, $urandom_range(20, 12));
            else if (sel < 8)
                run_phase(MODE_FLOOD, 20);
            else
                run_phase(MODE_NOISE, 10);
            wait_idle();
        end

        // closing stretch with no idling on either side
        tx_idle_on = 1'b0;
        stall_odds = 0;
        set_limits($urandom_range(8, 1), $urandom_range(500, 1));
        run_phase(MODE_REPEAT, 20);
        wait_idle();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/shrb_pkg.sv
rtl/core/shrb_table.sv
rtl/core/shrb_eval.sv
rtl/core/shrb_out.sv
rtl/core/source_hit_rate_blocker.sv
rtl/core/shrb_checker.sv
tb/tb_source_hit_rate_blocker.sv
